// ===== rtl/core/chkv_pkg.sv =====
package chkv_pkg;

    localparam int CAPACITY = 256;
    localparam int BUCKETS  = 64;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int PTR_W    = SLOT_W + 1;
    localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CNT_W    = 9;

    // Link value that marks the end of a chain or an empty bucket.
    localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_SET    = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        t_action           action;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  write_value;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  read_value;
        logic [CNT_W-1:0]  entry_count;
    } t_out_word;

    typedef struct packed {
        logic    load_req;
        logic    take_head;
        logic    advance;
        logic    clear_all;
        logic    write_value;
        logic    write_new;
        logic    link;
        logic    unlink;
        logic    set_res;
        t_status res_status;
        logic    take_value;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    head_nil;
        logic    hit;
        logic    walk_end;
        logic    full;
        logic    out_busy;
    } t_sts;

endpackage

// ===== rtl/core/chkv_ram.sv =====
module chkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/chkv_ctrl.sv =====
module chkv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  chkv_pkg::t_action i_in_action,
    output logic             o_in_ready,
    input  chkv_pkg::t_sts   i_sts,
    output chkv_pkg::t_cmd   o_cmd
);
    import chkv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_HEAD, S_CMP, S_ALLOC, S_LINK, S_DONE
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_comb begin
        cmd = '0;
        cmd.res_status = ST_OK;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_req = 1'b1;
                    if (i_in_action == ACT_CLEAR) begin
                        cmd.clear_all = 1'b1;
                        cmd.set_res   = 1'b1;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_HEAD;
                    end
                end
            end
            S_HEAD, S_CMP: begin
                if (r_state == S_HEAD) begin
                    cmd.take_head = 1'b1;
                end
                if (r_state == S_CMP && i_sts.hit) begin
                    cmd.set_res = 1'b1;
                    n_state     = S_DONE;
                    case (i_sts.act)
                        ACT_LOOKUP: cmd.take_value  = 1'b1;
                        ACT_SET:    cmd.write_value = 1'b1;
                        default:    cmd.unlink      = 1'b1;
                    endcase
                end else if (r_state == S_HEAD && !i_sts.head_nil) begin
                    n_state = S_CMP;
                end else if (r_state == S_CMP && !i_sts.walk_end) begin
                    cmd.advance = 1'b1;
                    n_state     = S_CMP;
                end else begin
                    // The chain ended without a match; the tail is kept as predecessor.
                    cmd.advance = (r_state == S_CMP);
                    if (i_sts.act == ACT_SET && !i_sts.full) begin
                        n_state = S_ALLOC;
                    end else begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = (i_sts.act == ACT_SET) ? ST_FULL : ST_NOT_FOUND;
                        n_state        = S_DONE;
                    end
                end
            end
            S_ALLOC: begin
                cmd.write_new = 1'b1;
                n_state       = S_LINK;
            end
            S_LINK: begin
                cmd.link    = 1'b1;
                cmd.set_res = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

// ===== rtl/core/chkv_dp.sv =====
module chkv_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  chkv_pkg::t_in_word  i_in_word,
    input  chkv_pkg::t_cmd      i_cmd,
    output chkv_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output chkv_pkg::t_out_word o_out_word
);
    import chkv_pkg::*;

    t_action            r_act;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;
    logic [PTR_W-1:0]   r_cur;
    logic [PTR_W-1:0]   r_prev;
    logic [CNT_W-1:0]   r_steps;
    logic [SLOT_W-1:0]  r_free;
    logic [CNT_W-1:0]   r_count;
    logic [BUCKETS-1:0] r_head_vld;
    logic [CAPACITY-1:0] r_free_vld;
    t_status            r_res_status;
    logic [VAL_W-1:0]   r_res_rd;
    logic               r_out_valid;
    t_out_word          r_out;

    logic [BKT_W-1:0]   bkt;
    logic [PTR_W-1:0]   head_rd, head_cur, next_rd;
    logic [KEY_W-1:0]   key_rd;
    logic [VAL_W-1:0]   val_rd;
    logic [SLOT_W-1:0]  free_rd, free_ent, cnt_idx, pop_idx, slot_raddr;
    logic [CNT_W-1:0]   cnt_dec;
    logic               prev_nil, head_we, next_we, free_we;
    logic [PTR_W-1:0]   head_wdata, next_wdata;

    assign bkt      = r_key[BKT_W-1:0];
    assign prev_nil = (r_prev >= NIL);
    assign cnt_idx  = r_count[SLOT_W-1:0];
    assign cnt_dec  = r_count - CNT_W'(1);
    assign pop_idx  = cnt_dec[SLOT_W-1:0];
    assign head_cur = r_head_vld[bkt] ? head_rd : NIL;
    assign free_ent = r_free_vld[cnt_idx] ? free_rd : cnt_idx;
    assign slot_raddr = i_cmd.take_head ? head_cur[SLOT_W-1:0] : next_rd[SLOT_W-1:0];

    assign head_we    = (i_cmd.link || i_cmd.unlink) && prev_nil;
    assign head_wdata = i_cmd.link ? {1'b0, r_free} : next_rd;
    assign next_we    = i_cmd.write_new || ((i_cmd.link || i_cmd.unlink) && !prev_nil);
    assign next_wdata = i_cmd.write_new ? NIL : (i_cmd.link ? {1'b0, r_free} : next_rd);
    assign free_we    = i_cmd.unlink && (r_count != '0);

    chkv_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(bkt), .i_wdata(head_wdata),
        .i_raddr(i_in_word.key[BKT_W-1:0]), .o_rdata(head_rd)
    );

    chkv_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key (
        .i_clk(i_clk), .i_we(i_cmd.write_new), .i_waddr(r_free), .i_wdata(r_key),
        .i_raddr(slot_raddr), .o_rdata(key_rd)
    );

    chkv_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val (
        .i_clk(i_clk), .i_we(i_cmd.write_value || i_cmd.write_new),
        .i_waddr(i_cmd.write_new ? r_free : r_cur[SLOT_W-1:0]), .i_wdata(r_val),
        .i_raddr(slot_raddr), .o_rdata(val_rd)
    );

    chkv_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_next (
        .i_clk(i_clk), .i_we(next_we),
        .i_waddr(i_cmd.write_new ? r_free : r_prev[SLOT_W-1:0]), .i_wdata(next_wdata),
        .i_raddr(slot_raddr), .o_rdata(next_rd)
    );

    chkv_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free (
        .i_clk(i_clk), .i_we(free_we), .i_waddr(pop_idx), .i_wdata(r_cur[SLOT_W-1:0]),
        .i_raddr(cnt_idx), .o_rdata(free_rd)
    );

    // Request, walk and result registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_act <= i_in_word.action;
            r_key <= i_in_word.key;
            r_val <= i_in_word.write_value;
        end
        if (i_cmd.take_head) begin
            r_cur   <= head_cur;
            r_prev  <= NIL;
            r_steps <= CNT_W'(1);
            r_free  <= free_ent;
        end else if (i_cmd.advance) begin
            r_cur   <= next_rd;
            r_prev  <= r_cur;
            r_steps <= r_steps + CNT_W'(1);
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_rd     <= i_cmd.take_value ? val_rd : '0;
        end
        if (i_cmd.load_out) begin
            r_out.status      <= r_res_status;
            r_out.read_value  <= r_res_rd;
            r_out.entry_count <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_head_vld  <= '0;
            r_free_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_count    <= '0;
                r_head_vld <= '0;
                r_free_vld <= '0;
            end else begin
                if (i_cmd.write_new) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (free_we) begin
                    r_count <= cnt_dec;
                end
                if (head_we) begin
                    r_head_vld[bkt] <= 1'b1;
                end
                if (free_we) begin
                    r_free_vld[pop_idx] <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.act      = r_act;
    assign o_sts.head_nil = (head_cur >= NIL);
    assign o_sts.hit      = (key_rd == r_key);
    assign o_sts.walk_end = (next_rd >= NIL) || (r_steps >= CNT_W'(CAPACITY));
    assign o_sts.full     = (r_count >= CNT_W'(CAPACITY));
    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_all |=> (r_count == '0) && (r_head_vld == '0))
        else $error("clear left entries behind");
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_new |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("allocation did not count the new entry");

endmodule

// ===== rtl/core/chained_hash_key_value_store_core.sv =====
// Chained hash key-value store.
// The input channel (i_in_valid / o_in_ready) takes one request word holding an
// action, a key and a write value. The output channel (o_out_valid / i_out_ready)
// returns one result word per request: a status, the value read by a lookup and
// the number of stored entries after the request.
// The bucket is the low bits of the key. A request reads the bucket head, then
// compares one chain entry per cycle, because the slot memories have a single
// registered read port. A lookup, update or delete that matches ends the walk at
// that compare; an insert follows its walk with a slot write, then a link, and a
// clear skips head read and walk. The block works on one request at a time and
// accepts the next one once the previous result sits in the output register,
// even while the receiver has not taken it yet.
// When the receiver stalls with a full output register, a finished request waits
// and input acceptance stops until the output register drains.
// Synchronous reset empties every bucket and refills the free list at once
// through valid bits; no clearing pass is needed.
module chained_hash_key_value_store_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  chkv_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output chkv_pkg::t_out_word o_out_word
);
    import chkv_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller sequences head read, chain walk, allocation and linking.
    chkv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_action(i_in_word.action),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the memories, the walk pointers and the result register.
    chkv_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

endmodule
